[src/ffra_pkg.sv]
// Package with the shared types, codes and defaults of the first-fit region allocator.
`default_nettype none
package ffra_pkg;

   localparam int unsigned MAX_SLOTS_DEF  = 64;
   localparam int unsigned TAIL_ALIGN_DEF = 4;
   localparam int unsigned DATA_W         = 32;
   localparam int unsigned CUR_W          = 33;
   localparam int unsigned SLOTS_W        = 7;
   localparam int unsigned LIM_W          = 9;

   typedef enum logic [1:0] {
      CMD_WRITE     = 2'd0,
      CMD_FIRST_FIT = 2'd1,
      CMD_TAIL      = 2'd2,
      CMD_UNUSED    = 2'd3
   } ffra_cmd_type;

   typedef enum logic [1:0] {
      STS_OK      = 2'd0,
      STS_INVALID = 2'd1,
      STS_NOSPACE = 2'd2
   } ffra_status_type;

   typedef enum logic [1:0] {
      CSR_DATA_START   = 2'd0,
      CSR_REGION_END   = 2'd1,
      CSR_SLOTS_IN_USE = 2'd2
   } ffra_csr_type;

   typedef enum logic [1:0] {
      KIND_EMPTY   = 2'd0,
      KIND_VALID   = 2'd1,
      KIND_WRITING = 2'd2,
      KIND_DELETED = 2'd3
   } ffra_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_ALIGN,
      ST_FINISH
   } ffra_state_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [DATA_W-1:0] size;
      logic [DATA_W-1:0] start;
   } ffra_entry_type;

   function automatic logic ffra_occupied(input logic [1:0] kind);
      return (kind == KIND_VALID) || (kind == KIND_WRITING);
   endfunction

endpackage
`default_nettype wire

[src/ffra_req_if.sv]
// Request channel interface of the allocator.
`default_nettype none
interface ffra_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [5:0]  slot;
   logic [31:0] slot_offset;
   logic [31:0] slot_capacity;
   logic [1:0]  slot_state;
   logic [31:0] request_size;

   modport source (output valid, command, slot, slot_offset, slot_capacity, slot_state,
                   request_size, input ready);
   modport sink (input valid, command, slot, slot_offset, slot_capacity, slot_state,
                 request_size, output ready);
endinterface
`default_nettype wire

[src/ffra_rsp_if.sv]
// Response channel interface of the allocator.
`default_nettype none
interface ffra_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] alloc_offset;
   logic [31:0] max_capacity;

   modport source (output valid, status, alloc_offset, max_capacity, input ready);
   modport sink (input valid, status, alloc_offset, max_capacity, output ready);
endinterface
`default_nettype wire

[src/ffra_csr_if.sv]
// Register write channel interface of the allocator.
`default_nettype none
interface ffra_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[src/ffra_dir.sv]
// Directory memory with one write port, one registered read port and per-slot valid bits.
`default_nettype none
module ffra_dir import ffra_pkg::*; #(
   parameter int unsigned MAX_SLOTS = MAX_SLOTS_DEF,
   parameter int unsigned IDX_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           wr_en,
   input  wire logic [IDX_W-1:0] wr_addr,
   input  wire ffra_entry_type wr_entry,
   input  wire logic           rd_en,
   input  wire logic [IDX_W-1:0] rd_addr,
   output ffra_entry_type      rd_entry
);

   ffra_entry_type mem [MAX_SLOTS];
   logic [MAX_SLOTS-1:0] used_ff;
   ffra_entry_type       rd_data_ff;
   logic                 rd_used_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff    <= '0;
         rd_used_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            used_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_used_ff <= used_ff[rd_addr];
         end
      end
   end

   always_comb begin
      rd_entry = rd_data_ff;
      if (!rd_used_ff) begin
         rd_entry.kind = KIND_EMPTY;
      end
   end

endmodule
`default_nettype wire

[src/first_fit_region_allocator.sv]
// A slot write or a rejected command answers in the cycle after acceptance. A directory pass
// covers L = min(slots_in_use, MAX_SLOTS) slots; first-fit runs one pass per occupied range
// visited plus a final pass when none is left, tail allocation one pass followed by the align
// and finish states when the end found lies below region_end. One item at a time; a new word
// is taken the cycle after the answer is accepted. Reset clears the registers to data_start 0,
// region_end 0, slots_in_use 64 and marks every directory slot empty at once through per-slot valid bits.
`default_nettype none
module first_fit_region_allocator import ffra_pkg::*; #(
   parameter int unsigned MAX_SLOTS  = MAX_SLOTS_DEF,
   parameter int unsigned TAIL_ALIGN = TAIL_ALIGN_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   ffra_req_if.sink  req_ch,
   ffra_rsp_if.source rsp_ch,
   ffra_csr_if.sink  csr_ch
);

   localparam int unsigned IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int unsigned CNT_W = $clog2(MAX_SLOTS + 1);
   localparam int unsigned ALIGN_L = $clog2(TAIL_ALIGN);
   localparam int unsigned PROD_W  = 2 * DATA_W + ALIGN_L + 1;
   localparam logic [63:0] ALIGN_M =
      ((64'd1 << (DATA_W + ALIGN_L)) + 64'(TAIL_ALIGN) - 64'd1) / 64'(TAIL_ALIGN);
   localparam logic [CUR_W-1:0] ALIGN_C = CUR_W'(TAIL_ALIGN);
   localparam logic [LIM_W-1:0] MAX_LIM   = LIM_W'(MAX_SLOTS);

   ffra_state_type state_ff, state_in;
   ffra_cmd_type   cmd_ff, cmd_in;
   logic [DATA_W-1:0] need_ff, need_in;
   logic [CUR_W-1:0]  cur_ff, cur_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic              have_prev_ff, have_prev_in;
   logic [DATA_W-1:0] prev_off_ff, prev_off_in;
   logic [IDX_W-1:0]  prev_idx_ff, prev_idx_in;
   logic              best_found_ff, best_found_in;
   logic [DATA_W-1:0] best_off_ff, best_off_in;
   logic [CUR_W-1:0]  best_end_ff, best_end_in;
   logic [IDX_W-1:0]  best_idx_ff, best_idx_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic              rsp_vld_ff, rsp_vld_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0] rsp_offset_ff, rsp_offset_in;
   logic [DATA_W-1:0] rsp_cap_ff, rsp_cap_in;
   logic [DATA_W-1:0] data_start_ff, data_start_in;
   logic [DATA_W-1:0] region_end_ff, region_end_in;
   logic [SLOTS_W-1:0] slots_ff, slots_in;

   logic req_acc;
   logic [LIM_W-1:0] slots_ext, lim_ext, slot_ext;
   logic [CNT_W-1:0] limit;
   logic issue, pass_done;
   logic dir_we;
   ffra_entry_type wr_entry, rd_entry;
   logic occ, after_prev, better;
   logic [CUR_W-1:0] e_end, off_ext, gap, reg_ext, room, end_max;
   logic hit, fin_ok, cur_below;
   logic [PROD_W-1:0] q_prod;
   logic [CUR_W-1:0] q_mul;
   logic [CUR_W-1:0] aligned;
   logic tail_ok;

   function automatic logic [DATA_W-1:0] room_tail(input logic [CUR_W-1:0] r,
                                                  input logic [CUR_W-1:0] a);
      logic [CUR_W-1:0] d;
      d = r - a;
      return d[DATA_W-1:0];
   endfunction

   assign req_acc = req_ch.valid & req_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE) && !rsp_vld_ff;
   assign csr_ch.ready = 1'b1;

   assign slots_ext = {{(LIM_W - SLOTS_W){1'b0}}, slots_ff};
   assign lim_ext   = (slots_ext < MAX_LIM) ? slots_ext : MAX_LIM;
   assign limit     = lim_ext[CNT_W-1:0];
   assign slot_ext  = {{(LIM_W - 6){1'b0}}, req_ch.slot};

   assign issue     = (state_ff == ST_SCAN) && (idx_ff < limit);
   assign pass_done = (state_ff == ST_SCAN) && !issue && !rd_vld_ff;

   assign dir_we = req_acc && (ffra_cmd_type'(req_ch.command) == CMD_WRITE) &&
                   (slot_ext < MAX_LIM);
   assign wr_entry = '{kind: req_ch.slot_state, size: req_ch.slot_capacity,
                       start: req_ch.slot_offset};

   ffra_dir #(.MAX_SLOTS(MAX_SLOTS), .IDX_W(IDX_W)) u_dir (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (dir_we),
      .wr_addr  (slot_ext[IDX_W-1:0]),
      .wr_entry (wr_entry),
      .rd_en    (issue),
      .rd_addr  (idx_ff[IDX_W-1:0]),
      .rd_entry (rd_entry)
   );

   assign occ   = rd_vld_ff && ffra_occupied(rd_entry.kind);
   assign e_end = {1'b0, rd_entry.start} + {1'b0, rd_entry.size};
   assign after_prev = !have_prev_ff || (rd_entry.start > prev_off_ff) ||
                       ((rd_entry.start == prev_off_ff) && (rd_idx_ff > prev_idx_ff));
   assign better = !best_found_ff || (rd_entry.start < best_off_ff);
   assign end_max = (occ && (e_end > cur_ff)) ? e_end : cur_ff;

   assign off_ext   = {1'b0, best_off_ff};
   assign gap       = off_ext - cur_ff;
   assign hit       = (off_ext >= cur_ff) && (gap >= {1'b0, need_ff});
   assign reg_ext   = {1'b0, region_end_ff};
   assign room      = reg_ext - cur_ff;
   assign cur_below = cur_ff < reg_ext;
   assign fin_ok    = cur_below && (room >= {1'b0, need_ff});

   assign q_prod  = PROD_W'(cur_ff[DATA_W-1:0]) * PROD_W'(ALIGN_M[DATA_W:0]);
   assign q_mul   = CUR_W'(quo_ff) * ALIGN_C;
   assign aligned = (q_mul == cur_ff) ? cur_ff : (q_mul + ALIGN_C);
   assign tail_ok = aligned < reg_ext;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if ((ffra_cmd_type'(req_ch.command) == CMD_FIRST_FIT &&
                    req_ch.request_size != '0) ||
                   ffra_cmd_type'(req_ch.command) == CMD_TAIL) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (pass_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (cmd_ff == CMD_TAIL) begin
               state_in = cur_below ? ST_ALIGN : ST_IDLE;
            end else if (best_found_ff && !hit) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_ALIGN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd_in        = cmd_ff;
      need_in       = need_ff;
      cur_in        = cur_ff;
      idx_in        = idx_ff;
      rd_vld_in     = issue;
      rd_idx_in     = idx_ff[IDX_W-1:0];
      have_prev_in  = have_prev_ff;
      prev_off_in   = prev_off_ff;
      prev_idx_in   = prev_idx_ff;
      best_found_in = best_found_ff;
      best_off_in   = best_off_ff;
      best_end_in   = best_end_ff;
      best_idx_in   = best_idx_ff;
      quo_in        = quo_ff;
      rsp_vld_in    = rsp_vld_ff & ~rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_cap_in    = rsp_cap_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               cmd_in        = ffra_cmd_type'(req_ch.command);
               need_in       = req_ch.request_size;
               cur_in        = {1'b0, data_start_ff};
               idx_in        = '0;
               have_prev_in  = 1'b0;
               best_found_in = 1'b0;
               rsp_offset_in = '0;
               rsp_cap_in    = '0;
               case (ffra_cmd_type'(req_ch.command))
                  CMD_WRITE: begin
                     rsp_vld_in    = 1'b1;
                     rsp_status_in = (slot_ext < MAX_LIM) ? STS_OK : STS_INVALID;
                  end
                  CMD_FIRST_FIT: begin
                     if (req_ch.request_size == '0) begin
                        rsp_vld_in    = 1'b1;
                        rsp_status_in = STS_INVALID;
                     end
                  end
                  CMD_TAIL: begin
                  end
                  default: begin
                     rsp_vld_in    = 1'b1;
                     rsp_status_in = STS_INVALID;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (issue) begin
               idx_in = idx_ff + 1'b1;
            end
            if (cmd_ff == CMD_TAIL) begin
               cur_in = end_max;
            end else if (occ && after_prev && better) begin
               best_found_in = 1'b1;
               best_off_in   = rd_entry.start;
               best_end_in   = e_end;
               best_idx_in   = rd_idx_ff;
            end
         end
         ST_DECIDE: begin
            if (cmd_ff == CMD_TAIL) begin
               if (!cur_below) begin
                  rsp_vld_in    = 1'b1;
                  rsp_status_in = STS_NOSPACE;
               end
            end else if (best_found_ff) begin
               if (hit) begin
                  rsp_vld_in    = 1'b1;
                  rsp_status_in = STS_OK;
                  rsp_offset_in = cur_ff[DATA_W-1:0];
               end else begin
                  if (best_end_ff > cur_ff) begin
                     cur_in = best_end_ff;
                  end
                  have_prev_in  = 1'b1;
                  prev_off_in   = best_off_ff;
                  prev_idx_in   = best_idx_ff;
                  best_found_in = 1'b0;
                  idx_in        = '0;
               end
            end else begin
               rsp_vld_in    = 1'b1;
               rsp_status_in = fin_ok ? STS_OK : STS_NOSPACE;
               rsp_offset_in = fin_ok ? cur_ff[DATA_W-1:0] : '0;
            end
         end
         ST_ALIGN: begin
            quo_in = q_prod[(DATA_W + ALIGN_L) +: DATA_W];
         end
         ST_FINISH: begin
            rsp_vld_in    = 1'b1;
            rsp_status_in = tail_ok ? STS_OK : STS_NOSPACE;
            rsp_offset_in = tail_ok ? aligned[DATA_W-1:0] : '0;
            rsp_cap_in    = tail_ok ? room_tail(reg_ext, aligned) : '0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      data_start_in = data_start_ff;
      region_end_in = region_end_ff;
      slots_in      = slots_ff;
      if (csr_ch.valid) begin
         case (ffra_csr_type'(csr_ch.index))
            CSR_DATA_START:   data_start_in = csr_ch.data;
            CSR_REGION_END:   region_end_in = csr_ch.data;
            CSR_SLOTS_IN_USE: slots_in      = csr_ch.data[SLOTS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rd_vld_ff     <= 1'b0;
         rsp_vld_ff    <= 1'b0;
         data_start_ff <= '0;
         region_end_ff <= '0;
         slots_ff      <= SLOTS_W'(64);
      end else begin
         state_ff      <= state_in;
         rd_vld_ff     <= rd_vld_in;
         rsp_vld_ff    <= rsp_vld_in;
         data_start_ff <= data_start_in;
         region_end_ff <= region_end_in;
         slots_ff      <= slots_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      need_ff       <= need_in;
      cur_ff        <= cur_in;
      idx_ff        <= idx_in;
      rd_idx_ff     <= rd_idx_in;
      have_prev_ff  <= have_prev_in;
      prev_off_ff   <= prev_off_in;
      prev_idx_ff   <= prev_idx_in;
      best_found_ff <= best_found_in;
      best_off_ff   <= best_off_in;
      best_end_ff   <= best_end_in;
      best_idx_ff   <= best_idx_in;
      quo_ff        <= quo_in;
      rsp_status_ff <= rsp_status_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_cap_ff    <= rsp_cap_in;
   end

   assign rsp_ch.valid        = rsp_vld_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.alloc_offset = rsp_offset_ff;
   assign rsp_ch.max_capacity = rsp_cap_ff;

   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !dir_we)
      else $error("directory written during a scan");

   a_read_from_scan: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> $past(state_ff == ST_SCAN))
      else $error("read data returned outside a scan");

   a_align_tail_only: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ALIGN) |-> (cmd_ff == CMD_TAIL))
      else $error("alignment entered for a command other than tail allocation");

endmodule
`default_nettype wire
